/* rtl/pbsr_pkg.sv */
// Package for the PAM baseband sample renderer.
// Holds rate and level constants, mode codes, queue entry types and the level function.
// No dependencies.
package pbsr_pkg;

    localparam int PCM_RATE   = 19200;
    localparam int LEVEL_PEAK = 32767;

    localparam int SPR_2400 = PCM_RATE / 2400;
    localparam int SPR_4800 = PCM_RATE / 4800;
    localparam int SPR_9600 = PCM_RATE / 9600;

    localparam logic [1:0] BAUD_2400    = 2'd0;
    localparam logic [1:0] BAUD_4800    = 2'd1;
    localparam logic [1:0] BAUD_9600    = 2'd2;
    localparam logic [1:0] BAUD_INVALID = 2'd3;

    localparam logic [1:0] MOD_NRZ     = 2'd0;
    localparam logic [1:0] MOD_PAM4    = 2'd1;
    localparam logic [1:0] MOD_PAM16   = 2'd2;
    localparam logic [1:0] MOD_INVALID = 2'd3;

    localparam logic [1:0] REG_BAUD = 2'd0;
    localparam logic [1:0] REG_MOD  = 2'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic signed [16:0] LVL_OFFSET = 17'(LEVEL_PEAK);
    localparam logic signed [16:0] PAM4_STEP  = 17'(2 * (LEVEL_PEAK / 3));
    localparam logic signed [16:0] PAM16_STEP = 17'(2 * (LEVEL_PEAK / 15));
    localparam logic signed [15:0] NRZ_HIGH   = 16'sh7FFF;
    localparam logic signed [15:0] NRZ_LOW    = 16'sh8000;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] mode;
        logic [2:0] spr_m1;
        logic       err;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_pull;

    function automatic logic signed [15:0] level_of(input logic [1:0] mode,
                                                    input logic [3:0] v);
        logic signed [16:0] acc;
        logic signed [4:0]  sv;
        sv  = $signed({1'b0, v});
        acc = '0;
        case (mode)
            MOD_NRZ: begin
                acc = (v[0]) ? 17'(NRZ_HIGH) : 17'(NRZ_LOW);
            end
            MOD_PAM4: begin
                acc = sv * PAM4_STEP - LVL_OFFSET;
            end
            default: begin
                acc = sv * PAM16_STEP - LVL_OFFSET;
            end
        endcase
        return acc[15:0];
    endfunction

endpackage

/* rtl/pbsr_ifs.sv */
// Valid/ready channel interfaces of the PAM baseband sample renderer.
// Depends on pbsr_pkg for the configuration port widths.
interface pbsr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface pbsr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_of_byte;
    logic               buffer_end;
    logic               setting_error;

    modport source (output valid, output sample, output last_of_byte,
                    output buffer_end, output setting_error, input ready);
    modport sink   (input valid, input sample, input last_of_byte,
                    input buffer_end, input setting_error, output ready);
endinterface

interface pbsr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pbsr_pkg::CFG_IDX_W-1:0]   index;
    logic [pbsr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pbsr_front.sv */
// Front end: holds the baud and modulation registers, accepts bytes and
// classifies each into a queue entry. Depends on pbsr_pkg and pbsr_ifs.
module pbsr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbsr_in_if.sink           i_in,
    pbsr_cfg_if.sink          i_cfg,
    input  logic              i_full,
    output pbsr_pkg::t_push   o_push
);
    import pbsr_pkg::*;

    logic [1:0] r_baud;
    logic [1:0] r_mod;
    logic [2:0] spr_m1;
    logic       err;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud <= BAUD_2400;
            r_mod  <= MOD_NRZ;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BAUD: r_baud <= i_cfg.data;
                REG_MOD:  r_mod  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        err = (r_baud == BAUD_INVALID) || (r_mod == MOD_INVALID);
        case (r_baud)
            BAUD_2400: spr_m1 = 3'(SPR_2400 - 1);
            BAUD_4800: spr_m1 = 3'(SPR_4800 - 1);
            default:   spr_m1 = 3'(SPR_9600 - 1);
        endcase
    end

    assign o_push.valid      = i_in.valid && !i_full;
    assign o_push.job.data   = i_in.data_byte;
    assign o_push.job.fin    = i_in.final_byte;
    assign o_push.job.mode   = r_mod;
    assign o_push.job.spr_m1 = spr_m1;
    assign o_push.job.err    = err;

endmodule

/* rtl/pbsr_queue.sv */
// Two-entry queue of classified bytes between front and back end.
// Depends on pbsr_pkg.
module pbsr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbsr_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_full,
    output pbsr_pkg::t_pull   o_pull
);
    import pbsr_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_pull.valid = (r_cnt != 2'd0);
    assign o_pull.job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(i_pop);
        end
    end

endmodule

/* rtl/pbsr_back.sv */
// Back end: renders one queued byte into samples, one per cycle unless
// stalled, into the registered output stage. Depends on pbsr_pkg and pbsr_ifs.
module pbsr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbsr_pkg::t_pull   i_pull,
    output logic              o_pop,
    pbsr_out_if.source        o_out
);
    import pbsr_pkg::*;

    logic               r_busy, n_busy;
    logic [7:0]         r_data, n_data;
    logic [1:0]         r_mode, n_mode;
    logic               r_fin, n_fin;
    logic               r_err, n_err;
    logic [2:0]         r_spr_m1, n_spr_m1;
    logic [2:0]         r_rep, n_rep;
    logic [2:0]         r_sym, n_sym;

    logic               r_ovalid;
    logic signed [15:0] r_sample;
    logic               r_last;
    logic               r_end;
    logic               r_serr;

    logic               adv;
    logic               fire;
    logic               last_s;
    logic               load;
    logic [3:0]         v;
    logic signed [15:0] lvl;
    logic [2:0]         nsym_m1;
    logic [7:0]         shifted;

    assign adv    = !r_ovalid || o_out.ready;
    assign fire   = adv && r_busy;
    assign last_s = r_err || ((r_rep == 3'd0) && (r_sym == 3'd0));
    assign load   = i_pull.valid && (!r_busy || (fire && last_s));
    assign o_pop  = load;

    always_comb begin
        case (r_mode)
            MOD_NRZ: begin
                v       = {3'b000, r_data[7]};
                shifted = {r_data[6:0], 1'b0};
            end
            MOD_PAM4: begin
                v       = {2'b00, r_data[7:6]};
                shifted = {r_data[5:0], 2'b00};
            end
            default: begin
                v       = r_data[7:4];
                shifted = {r_data[3:0], 4'b0000};
            end
        endcase
        lvl = r_err ? 16'sd0 : level_of(r_mode, v);
    end

    always_comb begin
        case (i_pull.job.mode)
            MOD_NRZ:  nsym_m1 = 3'd7;
            MOD_PAM4: nsym_m1 = 3'd3;
            default:  nsym_m1 = 3'd1;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_data   = r_data;
        n_mode   = r_mode;
        n_fin    = r_fin;
        n_err    = r_err;
        n_spr_m1 = r_spr_m1;
        n_rep    = r_rep;
        n_sym    = r_sym;
        if (load) begin
            n_busy   = 1'b1;
            n_data   = i_pull.job.data;
            n_mode   = i_pull.job.mode;
            n_fin    = i_pull.job.fin;
            n_err    = i_pull.job.err;
            n_spr_m1 = i_pull.job.spr_m1;
            n_rep    = i_pull.job.spr_m1;
            n_sym    = nsym_m1;
        end else if (fire) begin
            if (last_s) begin
                n_busy = 1'b0;
            end else if (r_rep == 3'd0) begin
                n_rep  = r_spr_m1;
                n_sym  = r_sym - 3'd1;
                n_data = shifted;
            end else begin
                n_rep = r_rep - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_mode   <= n_mode;
        r_fin    <= n_fin;
        r_err    <= n_err;
        r_spr_m1 <= n_spr_m1;
        r_rep    <= n_rep;
        r_sym    <= n_sym;
        if (fire) begin
            r_sample <= lvl;
            r_last   <= last_s;
            r_end    <= last_s && r_fin;
            r_serr   <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (adv) begin
                r_ovalid <= fire;
            end
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.sample        = r_sample;
    assign o_out.last_of_byte  = r_last;
    assign o_out.buffer_end    = r_end;
    assign o_out.setting_error = r_serr;

endmodule

/* rtl/pam_baseband_sample_renderer.sv */
// Takes one byte per input item and renders it into signed 16-bit PCM
// samples, one sample per output item and at most one per cycle. A byte
// yields symbols times samples per symbol items: NRZ 8, PAM4 4 or PAM16 2
// symbols, each repeated 8, 4 or 2 times for 2400, 4800 or 9600 baud at a
// 19200 sample rate, so 4 to 64 items per byte; an invalid setting gives a
// single error item. A two-entry queue lets up to two further bytes be
// accepted while one renders. Configuration writes are taken in any cycle
// and apply to bytes accepted later.
module pam_baseband_sample_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbsr_in_if.sink     i_in,
    pbsr_cfg_if.sink    i_cfg,
    pbsr_out_if.source  o_out
);
    import pbsr_pkg::*;

    t_push push;
    t_pull pull;
    logic  full;
    logic  pop;

    pbsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push)
    );

    pbsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_pull  (pull)
    );

    pbsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pull  (pull),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
